// ===== sv/sha1_pkg.sv =====
// Shared types, constants and round functions for the SHA-1 stream unit.
// No dependencies; imported by every module of the block.
package sha1_pkg;

  typedef logic [31:0] word_t;
  typedef word_t [4:0] chain_t;
  typedef logic [511:0] block_t;

  typedef enum logic [0:0] {
    OP_ABSORB = 1'b0,
    OP_FINISH = 1'b1
  } op_e;

  typedef struct packed {
    logic       valid;
    op_e        op;
    logic [7:0] data;
  } head_t;

  typedef struct packed {
    logic busy;
    logic upd;
  } rnd_stat_t;

  localparam chain_t     SHA1_IV    = {32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE,
                                       32'hEFCDAB89, 32'h67452301};
  localparam word_t      K_R0       = 32'h5A827999;
  localparam word_t      K_R1       = 32'h6ED9EBA1;
  localparam word_t      K_R2       = 32'h8F1BBCDC;
  localparam word_t      K_R3       = 32'hCA62C1D6;
  localparam logic [7:0] PAD_MARK   = 8'h80;
  localparam logic [7:0] PAD_ZERO   = 8'h00;
  localparam logic [5:0] FILL_LAST  = 6'd63;
  localparam logic [5:0] FILL_LEN   = 6'd56;
  localparam logic [6:0] ROUND_LAST = 7'd79;
  localparam logic [2:0] LEN_LAST   = 3'd7;
  localparam logic [2:0] WORD_LAST  = 3'd4;

  function automatic word_t round_k(logic [6:0] r);
    word_t k;
    if (r < 7'd20) begin
      k = K_R0;
    end else if (r < 7'd40) begin
      k = K_R1;
    end else if (r < 7'd60) begin
      k = K_R2;
    end else begin
      k = K_R3;
    end
    return k;
  endfunction

  function automatic word_t round_f(logic [6:0] r, word_t b, word_t c, word_t d);
    word_t f;
    if (r < 7'd20) begin
      f = (b & c) | (~b & d);
    end else if (r < 7'd40) begin
      f = b ^ c ^ d;
    end else if (r < 7'd60) begin
      f = (b & c) | (b & d) | (c & d);
    end else begin
      f = b ^ c ^ d;
    end
    return f;
  endfunction

endpackage

// ===== sv/sha1_in_if.sv =====
// Input channel of the SHA-1 stream unit: valid/ready plus command and byte.
// No dependencies.
interface sha1_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] data_byte;

  modport source (output valid, output command, output data_byte, input ready);
  modport sink   (input valid, input command, input data_byte, output ready);
endinterface

// ===== sv/sha1_out_if.sv =====
// Output channel of the SHA-1 stream unit: valid/ready plus one digest word.
// No dependencies.
interface sha1_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  modport source (output valid, output digest_word, output word_index, output last_word,
                  input ready);
  modport sink   (input valid, input digest_word, input word_index, input last_word,
                  output ready);
endinterface

// ===== sv/sha1_front.sv =====
// Front end: accepts items, decodes the command and queues them for the back end.
// Depends on sha1_pkg and sha1_in_if.
module sha1_front #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  sha1_in_if.sink         in_i,
  output sha1_pkg::head_t head_o,
  input  logic            pop_i
);
  import sha1_pkg::*;

  localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PtrW-1:0] PtrMax = PtrW'(QUEUE_DEPTH - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(QUEUE_DEPTH);

  op_e             op_q   [QUEUE_DEPTH];
  logic [7:0]      data_q [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            push, pop;

  assign in_i.ready  = (cnt_q != CntFull);
  assign push        = in_i.valid && in_i.ready;
  assign pop         = pop_i && (cnt_q != '0);
  assign head_o.valid = (cnt_q != '0);
  assign head_o.op    = op_q[rd_q];
  assign head_o.data  = data_q[rd_q];

  always_comb begin
    wr_d  = push ? ((wr_q == PtrMax) ? '0 : wr_q + 1'b1) : wr_q;
    rd_d  = pop  ? ((rd_q == PtrMax) ? '0 : rd_q + 1'b1) : rd_q;
    cnt_d = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      op_q[wr_q]   <= in_i.command ? OP_FINISH : OP_ABSORB;
      data_q[wr_q] <= in_i.data_byte;
    end
  end

endmodule

// ===== sv/sha1_round.sv =====
// Compression unit: one SHA-1 round per cycle with a 16-word schedule window,
// then RN_ADD adds the working words into the chaining value. Uses sha1_pkg.
module sha1_round (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  sha1_pkg::block_t    block_i,
  input  sha1_pkg::chain_t    h_i,
  output sha1_pkg::rnd_stat_t stat_o,
  output sha1_pkg::chain_t    h_new_o
);
  import sha1_pkg::*;

  typedef enum logic [1:0] {
    RN_IDLE,
    RN_RUN,
    RN_ADD
  } rn_state_e;

  rn_state_e  st_q;
  logic [6:0] cnt_q;
  word_t      w_q [16];
  word_t      a_q, b_q, c_q, d_q, e_q;
  word_t      t_sum, w_new, w_mix;

  assign w_mix = w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0];
  assign w_new = {w_mix[30:0], w_mix[31]};
  assign t_sum = {a_q[26:0], a_q[31:27]} + round_f(cnt_q, b_q, c_q, d_q) + e_q
               + round_k(cnt_q) + w_q[0];

  assign stat_o.busy = (st_q != RN_IDLE);
  assign stat_o.upd  = (st_q == RN_ADD);
  assign h_new_o[0]  = h_i[0] + a_q;
  assign h_new_o[1]  = h_i[1] + b_q;
  assign h_new_o[2]  = h_i[2] + c_q;
  assign h_new_o[3]  = h_i[3] + d_q;
  assign h_new_o[4]  = h_i[4] + e_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= RN_IDLE;
      cnt_q <= '0;
    end else begin
      case (st_q)
        RN_IDLE: begin
          if (start_i) begin
            st_q  <= RN_RUN;
            cnt_q <= '0;
          end
        end
        RN_RUN: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == ROUND_LAST) begin
            st_q <= RN_ADD;
          end
        end
        RN_ADD: begin
          st_q <= RN_IDLE;
        end
        default: begin
          st_q <= RN_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && (st_q == RN_IDLE)) begin
      for (int i = 0; i < 16; i++) begin
        w_q[i] <= block_i[511 - 32*i -: 32];
      end
      a_q <= h_i[0];
      b_q <= h_i[1];
      c_q <= h_i[2];
      d_q <= h_i[3];
      e_q <= h_i[4];
    end else if (st_q == RN_RUN) begin
      for (int i = 0; i < 15; i++) begin
        w_q[i] <= w_q[i+1];
      end
      w_q[15] <= w_new;
      a_q <= t_sum;
      b_q <= a_q;
      c_q <= {b_q[1:0], b_q[31:2]};
      d_q <= c_q;
      e_q <= d_q;
    end
  end

endmodule

// ===== sv/sha1_back.sv =====
// Back end: block loader, padding sequencer, chaining value and digest output stage.
// Depends on sha1_pkg, sha1_out_if and sha1_round.
module sha1_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  sha1_pkg::head_t head_i,
  output logic            pop_o,
  sha1_out_if.source      out_o
);
  import sha1_pkg::*;

  typedef enum logic [2:0] {
    LD_DATA,
    LD_MARK,
    LD_ZERO,
    LD_LEN,
    LD_WAIT,
    LD_OUT
  } ld_state_e;

  ld_state_e   st_q;
  logic [5:0]  fill_q, fill_nx;
  logic [63:0] bits_q, len_q;
  logic [2:0]  lidx_q, widx_q;
  logic [503:0] buf_q;
  chain_t      h_q, h_new;
  rnd_stat_t   rstat;
  logic        ovalid_q, olast_q;
  word_t       oword_q;
  logic [2:0]  oidx_q;
  logic        put_ok, put_en, start, out_free;
  logic [7:0]  put_byte;

  assign put_ok   = (fill_q != FILL_LAST) || !rstat.busy;
  assign start    = put_en && (fill_q == FILL_LAST);
  assign fill_nx  = fill_q + 1'b1;
  assign out_free = !ovalid_q || out_o.ready;

  always_comb begin
    pop_o    = 1'b0;
    put_en   = 1'b0;
    put_byte = PAD_ZERO;
    case (st_q)
      LD_DATA: begin
        if (head_i.valid && put_ok) begin
          pop_o    = 1'b1;
          put_en   = (head_i.op == OP_ABSORB);
          put_byte = head_i.data;
        end
      end
      LD_MARK: begin
        put_en   = put_ok;
        put_byte = PAD_MARK;
      end
      LD_ZERO: begin
        put_en   = put_ok;
      end
      LD_LEN: begin
        put_en   = put_ok;
        put_byte = len_q[63:56];
      end
      default: begin
        put_en   = 1'b0;
      end
    endcase
  end

  sha1_round u_round (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .block_i ({buf_q, put_byte}),
    .h_i     (h_q),
    .stat_o  (rstat),
    .h_new_o (h_new)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= LD_DATA;
      fill_q   <= '0;
      bits_q   <= '0;
      len_q    <= '0;
      lidx_q   <= '0;
      widx_q   <= '0;
      h_q      <= SHA1_IV;
      ovalid_q <= 1'b0;
      olast_q  <= 1'b0;
      oword_q  <= '0;
      oidx_q   <= '0;
    end else begin
      if (put_en) begin
        fill_q <= fill_nx;
      end
      if (rstat.upd) begin
        h_q <= h_new;
      end
      if (ovalid_q && out_o.ready && (st_q != LD_OUT)) begin
        ovalid_q <= 1'b0;
      end
      case (st_q)
        LD_DATA: begin
          if (pop_o) begin
            if (head_i.op == OP_ABSORB) begin
              bits_q <= bits_q + 64'd8;
            end else begin
              len_q  <= bits_q;
              bits_q <= '0;
              st_q   <= LD_MARK;
            end
          end
        end
        LD_MARK, LD_ZERO: begin
          if (put_en) begin
            lidx_q <= '0;
            st_q   <= (fill_nx == FILL_LEN) ? LD_LEN : LD_ZERO;
          end
        end
        LD_LEN: begin
          if (put_en) begin
            len_q  <= {len_q[55:0], 8'h00};
            lidx_q <= lidx_q + 1'b1;
            if (lidx_q == LEN_LAST) begin
              st_q <= LD_WAIT;
            end
          end
        end
        LD_WAIT: begin
          if (!rstat.busy) begin
            widx_q <= '0;
            st_q   <= LD_OUT;
          end
        end
        LD_OUT: begin
          if (out_free) begin
            ovalid_q <= 1'b1;
            oword_q  <= h_q[widx_q];
            oidx_q   <= widx_q;
            olast_q  <= (widx_q == WORD_LAST);
            if (widx_q == WORD_LAST) begin
              widx_q <= '0;
              h_q    <= SHA1_IV;
              st_q   <= LD_DATA;
            end else begin
              widx_q <= widx_q + 1'b1;
            end
          end
        end
        default: begin
          st_q <= LD_DATA;
        end
      endcase
    end
  end

  // block shift line: the 64th byte of a block goes straight to the round unit
  always_ff @(posedge clk_i) begin
    if (put_en) begin
      buf_q <= {buf_q[495:0], put_byte};
    end
  end

  assign out_o.valid       = ovalid_q;
  assign out_o.digest_word = oword_q;
  assign out_o.word_index  = oidx_q;
  assign out_o.last_word   = olast_q;

endmodule

// ===== sv/sha1_hash_stream_unit.sv =====
// Top level of the SHA-1 byte stream unit: front end queue and back end hashing core.
// Depends on sha1_pkg, sha1_in_if, sha1_out_if, sha1_front and sha1_back.
//
// Each absorb item carries one message byte; the back end loads one byte per cycle
// into a 64-byte block line (the last byte of a block waits while the round unit is
// busy) and hands each full block to a single round unit, which runs 80 rounds and
// then adds into the chaining value while the next block loads. Sustained absorb
// rate is set by the round unit. A finish item is taken, then the padding bytes load
// in the same way (the 0x80 marker, zeros up to byte 56, eight length bytes: 9 to 72
// bytes), the final compression runs, the result passes LD_WAIT and LD_OUT into the
// output register, and then five digest words follow, one per cycle while the output
// is taken. A queue of QUEUE_DEPTH items in front keeps input accepted, until it
// fills, while the core is busy or a digest word waits. No clearing pass after reset.
module sha1_hash_stream_unit #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  sha1_in_if.sink    in_i,
  sha1_out_if.source out_o
);
  import sha1_pkg::*;

  head_t head;
  logic  pop;

  sha1_front #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .head_o (head),
    .pop_i  (pop)
  );

  sha1_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .head_i (head),
    .pop_o  (pop),
    .out_o  (out_o)
  );

  a_last_marks_word4 : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.last_word == (out_o.word_index == WORD_LAST)))
    else $error("last_word does not match word_index");

  a_word_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.word_index <= WORD_LAST))
    else $error("digest word index out of range");

  a_digest_burst : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.ready && !out_o.last_word) |=>
      (out_o.valid && (out_o.word_index == $past(out_o.word_index) + 3'd1)))
    else $error("digest words not delivered in sequence");

  a_pop_needs_item : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> head.valid)
    else $error("back end took an item from an empty queue");

endmodule

// ===== tb/sha1_hash_stream_unit_tb.sv =====
`timescale 1ns / 100ps
// Self-checking bench for sha1_hash_stream_unit: byte and finish items in, digest words out.
// Depends on sha1_pkg, sha1_in_if, sha1_out_if and the unit; predicts digests in-bench.
module sha1_hash_stream_unit_tb;
  import sha1_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 300;
  localparam int MAX_GAP = 18;
  localparam int ITEM_TARGET = 110;
  localparam int WORD_TARGET = 40;

  typedef struct {
    op_e        op;
    logic [7:0] data;
  } feed_t;

  typedef struct {
    word_t      word;
    logic [2:0] idx;
    logic       last;
  } digest_t;

  logic clk_i;
  logic rst_ni = 1'b0;

  sha1_in_if  in_bus ();
  sha1_out_if out_bus ();

  sha1_hash_stream_unit uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  feed_t   feed_q[$];
  digest_t digest_q[$];

  // predicted hash state
  word_t       chain_st [5];
  logic [7:0]  blk_st [64];
  int unsigned fill_st;
  logic [63:0] nbits_st;

  int errors = 0;
  int items_in = 0;
  int msgs_done = 0;
  int words_seen = 0;
  int cycle_cnt = 0;

  feed_t drv_item;
  int    drv_hold = 0;
  int    drv_burst = 0;
  logic  drv_valid;
  logic  drv_load;
  int    mon_hold = 0;
  int    mon_burst = 0;
  logic  mon_ready;

  function automatic word_t rotl(word_t v, int n);
    return (v << n) | (v >> (32 - n));
  endfunction

  function automatic void hash_clear();
    chain_st[0] = 32'h67452301;
    chain_st[1] = 32'hEFCDAB89;
    chain_st[2] = 32'h98BADCFE;
    chain_st[3] = 32'h10325476;
    chain_st[4] = 32'hC3D2E1F0;
    foreach (blk_st[i]) blk_st[i] = 8'h00;
    fill_st = 0;
    nbits_st = 64'd0;
  endfunction

  function automatic void sha1_compress();
    word_t w [80];
    word_t a, b, c, d, e, f, k, t;
    int r;
    for (r = 0; r < 16; r++)
      w[r] = {blk_st[4*r], blk_st[4*r+1], blk_st[4*r+2], blk_st[4*r+3]};
    for (r = 16; r < 80; r++)
      w[r] = rotl(w[r-3] ^ w[r-8] ^ w[r-14] ^ w[r-16], 1);
    a = chain_st[0];
    b = chain_st[1];
    c = chain_st[2];
    d = chain_st[3];
    e = chain_st[4];
    for (r = 0; r < 80; r++) begin
      if (r < 20) begin
        f = (b & c) | (~b & d);
        k = K_R0;
      end else if (r < 40) begin
        f = b ^ c ^ d;
        k = K_R1;
      end else if (r < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = K_R2;
      end else begin
        f = b ^ c ^ d;
        k = K_R3;
      end
      t = rotl(a, 5) + f + e + k + w[r];
      e = d;
      d = c;
      c = rotl(b, 30);
      b = a;
      a = t;
    end
    chain_st[0] += a;
    chain_st[1] += b;
    chain_st[2] += c;
    chain_st[3] += d;
    chain_st[4] += e;
  endfunction

  function automatic void sha1_put_byte(logic [7:0] v);
    blk_st[fill_st] = v;
    fill_st++;
    if (fill_st == 64) begin
      sha1_compress();
      fill_st = 0;
    end
  endfunction

  function automatic void sha1_take_item(feed_t it);
    logic [63:0] len_bits;
    digest_t     dw;
    int          i;
    if (it.op == OP_ABSORB) begin
      sha1_put_byte(it.data);
      nbits_st += 64'd8;
    end else begin
      len_bits = nbits_st;
      sha1_put_byte(PAD_MARK);
      while (fill_st != 56) sha1_put_byte(PAD_ZERO);
      for (i = 0; i < 8; i++) sha1_put_byte(len_bits[63 - 8*i -: 8]);
      for (i = 0; i < 5; i++) begin
        dw.word = chain_st[i];
        dw.idx  = 3'(i);
        dw.last = (i == 4);
        digest_q.push_back(dw);
      end
      hash_clear();
    end
  endfunction

  // per-item wait, with occasional runs of back-to-back items
  function automatic int draw_gap(inout int burst_left);
    int g;
    if (burst_left > 0) begin
      burst_left--;
      g = 0;
    end else if ($urandom_range(0, 7) == 0) begin
      burst_left = $urandom_range(10, 30);
      g = 0;
    end else begin
      g = $urandom_range(0, MAX_GAP);
    end
    return g;
  endfunction

  task automatic report_mismatch(string msg);
    errors++;
    $display("MISMATCH at %0t ns: %s", $time, msg);
  endtask

  function automatic void push_item(op_e op, logic [7:0] data);
    feed_t it;
    it.op = op;
    it.data = data;
    feed_q.push_back(it);
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    in_bus.valid = 1'b0;
    in_bus.command = OP_ABSORB;
    in_bus.data_byte = 8'h00;
    out_bus.ready = 1'b0;
    hash_clear();
  end

  // item driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_bus.valid <= 1'b0;
      in_bus.command <= OP_ABSORB;
      in_bus.data_byte <= 8'h00;
    end else begin
      drv_load = 1'b0;
      drv_valid = in_bus.valid;
      if (in_bus.valid && in_bus.ready) begin
        sha1_take_item(drv_item);
        items_in++;
        if (drv_item.op == OP_FINISH) msgs_done++;
        drv_valid = 1'b0;
        drv_hold = draw_gap(drv_burst);
      end
      if (!drv_valid) begin
        if (drv_hold != 0) begin
          drv_hold--;
        end else if (feed_q.size() != 0) begin
          drv_item = feed_q.pop_front();
          drv_valid = 1'b1;
          drv_load = 1'b1;
        end
      end
      in_bus.valid <= drv_valid;
      if (drv_load) begin
        in_bus.command <= drv_item.op;
        in_bus.data_byte <= drv_item.data;
      end
    end
  end

  // digest monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_bus.ready <= 1'b0;
    end else begin
      mon_ready = out_bus.ready;
      if (out_bus.valid && out_bus.ready) begin
        words_seen++;
        if (digest_q.size() == 0) begin
          report_mismatch($sformatf("unexpected digest word %h index %0d",
                                    out_bus.digest_word, out_bus.word_index));
        end else begin
          digest_t ex;
          ex = digest_q.pop_front();
          if (out_bus.digest_word !== ex.word)
            report_mismatch($sformatf("digest_word %h, expected %h (index %0d)",
                                      out_bus.digest_word, ex.word, ex.idx));
          if (out_bus.word_index !== ex.idx)
            report_mismatch($sformatf("word_index %0d, expected %0d",
                                      out_bus.word_index, ex.idx));
          if (out_bus.last_word !== ex.last)
            report_mismatch($sformatf("last_word %b, expected %b (index %0d)",
                                      out_bus.last_word, ex.last, ex.idx));
        end
        mon_ready = 1'b0;
        mon_hold = draw_gap(mon_burst);
      end
      if (!mon_ready) begin
        if (mon_hold != 0) mon_hold--;
        else mon_ready = 1'b1;
      end
      out_bus.ready <= mon_ready;
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_cnt);
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    int n_items;
    int n_words;
    int len;
    int sel;
    int i;
    logic [7:0] edge_bytes [8];

    // empty message, then back-to-back finish with a nonzero ignored byte
    push_item(OP_FINISH, 8'h00);
    push_item(OP_FINISH, 8'hFF);
    // "abc"
    push_item(OP_ABSORB, 8'h61);
    push_item(OP_ABSORB, 8'h62);
    push_item(OP_ABSORB, 8'h63);
    push_item(OP_FINISH, 8'h5A);
    // byte extremes and alternating bit patterns
    edge_bytes = '{8'h00, 8'hFF, 8'hAA, 8'h55, 8'h80, 8'h7F, 8'h01, 8'hFE};
    for (i = 0; i < 8; i++) push_item(OP_ABSORB, edge_bytes[i]);
    push_item(OP_FINISH, 8'hA5);
    n_items = feed_q.size();
    n_words = 5 * 4;

    // random messages; some lengths sit on the padding boundaries
    while (n_items < ITEM_TARGET || n_words < WORD_TARGET) begin
      sel = $urandom_range(0, 9);
      if (sel == 0) begin
        case ($urandom_range(0, 5))
          0: len = 55;
          1: len = 56;
          2: len = 63;
          3: len = 64;
          4: len = 119;
          default: len = 120;
        endcase
      end else if (sel == 1) begin
        len = 0;
      end else begin
        len = $urandom_range(1, 20);
      end
      for (i = 0; i < len; i++) push_item(OP_ABSORB, 8'($urandom_range(0, 255)));
      push_item(OP_FINISH, 8'($urandom_range(0, 255)));
      n_items += len + 1;
      n_words += 5;
    end

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (!(feed_q.size() == 0 && !in_bus.valid && digest_q.size() == 0))
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Ran %0d items (%0d messages incl. empty and block-boundary lengths),",
             items_in, msgs_done);
    $display("checked %0d digest words under random stalls on both sides.", words_seen);
    if (errors == 0 && digest_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== sha1_hash_stream_unit.f =====
sv/sha1_pkg.sv
sv/sha1_in_if.sv
sv/sha1_out_if.sv
sv/sha1_front.sv
sv/sha1_round.sv
sv/sha1_back.sv
sv/sha1_hash_stream_unit.sv
tb/sha1_hash_stream_unit_tb.sv
